// File: rtl/core/qte_pkg.sv
// Shared widths, limits and the arctangent step table for the quaternion to Euler core.
package qte_pkg;

    localparam int QW            = 16;  // quaternion component width
    localparam int SW            = 35;  // product sums, 1.0 = 2^30
    localparam int CW            = 56;  // CORDIC x/y datapath
    localparam int ZW            = 34;  // angle accumulator, degrees * 2^23
    localparam int ATAN_ENTRIES  = 24;
    localparam int ISQRT_STEPS   = 31;
    localparam int QUEUE_DEPTH   = 4;
    localparam int DEF_DATA_WIDTH    = 16;
    localparam int DEF_CORDIC_STAGES = 16;

    localparam logic signed [ZW-1:0] HALF_TURN = ZW'(64'sd1509949440);
    localparam logic signed [SW-1:0] ONE_Q30   = SW'(64'sd1073741824);
    localparam logic signed [15:0]   LIMIT_180 = 16'sd23040;
    localparam logic signed [15:0]   LIMIT_90  = 16'sd11520;

    typedef struct packed {
        logic signed [SW-1:0] sr;
        logic signed [SW-1:0] cr;
        logic signed [SW-1:0] sp;
        logic signed [SW-1:0] sy;
        logic signed [SW-1:0] cy;
        logic                 sat_pos;
        logic                 sat_neg;
    } qte_item_t;

    function automatic logic [29:0] qte_atan(input int idx);
        logic [29:0] v;
        unique case (idx)
            0:  v = 30'd377487360;
            1:  v = 30'd222843801;
            2:  v = 30'd117744544;
            3:  v = 30'd59768969;
            4:  v = 30'd30000467;
            5:  v = 30'd15014858;
            6:  v = 30'd7509261;
            7:  v = 30'd3754860;
            8:  v = 30'd1877459;
            9:  v = 30'd938733;
            10: v = 30'd469367;
            11: v = 30'd234683;
            12: v = 30'd117342;
            13: v = 30'd58671;
            14: v = 30'd29335;
            15: v = 30'd14668;
            16: v = 30'd7334;
            17: v = 30'd3667;
            18: v = 30'd1833;
            19: v = 30'd917;
            20: v = 30'd458;
            21: v = 30'd229;
            22: v = 30'd115;
            23: v = 30'd57;
            default: v = 30'd0;
        endcase
        return v;
    endfunction

endpackage

// File: rtl/core/qte_front.sv
// Front end: rescale the quaternion, form the product sums and classify pitch saturation.
module qte_front import qte_pkg::*; #(
    parameter int DATA_WIDTH = DEF_DATA_WIDTH
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [QW-1:0]                 quat_w,
    input  logic [QW-1:0]                 quat_x,
    input  logic [QW-1:0]                 quat_y,
    input  logic [QW-1:0]                 quat_z,
    input  logic [$clog2(QUEUE_DEPTH+1)-1:0] q_count,
    output logic                          push,
    output qte_item_t                     push_item
);
    localparam int CNT_W = $clog2(QUEUE_DEPTH+1);

    logic signed [QW-1:0] w_s, x_s, y_s, z_s;
    logic f1_vld_reg, f2_vld_reg;
    logic signed [2*QW-1:0] wx_reg, yz_reg, xx_reg, yy_reg, wy_reg, zx_reg, wz_reg, xy_reg,
                            zz_reg;
    qte_item_t item_reg;
    logic [CNT_W:0] used;

    generate
        if (DATA_WIDTH > QW) begin : g_wide
            assign w_s = QW'(quat_w >> (DATA_WIDTH - QW));
            assign x_s = QW'(quat_x >> (DATA_WIDTH - QW));
            assign y_s = QW'(quat_y >> (DATA_WIDTH - QW));
            assign z_s = QW'(quat_z >> (DATA_WIDTH - QW));
        end else if (DATA_WIDTH < QW) begin : g_narrow
            assign w_s = {quat_w[DATA_WIDTH-1:0], {(QW-DATA_WIDTH){1'b0}}};
            assign x_s = {quat_x[DATA_WIDTH-1:0], {(QW-DATA_WIDTH){1'b0}}};
            assign y_s = {quat_y[DATA_WIDTH-1:0], {(QW-DATA_WIDTH){1'b0}}};
            assign z_s = {quat_z[DATA_WIDTH-1:0], {(QW-DATA_WIDTH){1'b0}}};
        end else begin : g_same
            assign w_s = quat_w;
            assign x_s = quat_x;
            assign y_s = quat_y;
            assign z_s = quat_z;
        end
    endgenerate

    // Credit: queue entries plus items in flight here must leave a free slot.
    assign used     = (CNT_W+1)'(q_count) + (CNT_W+1)'(f1_vld_reg) + (CNT_W+1)'(f2_vld_reg);
    assign in_ready = used < (CNT_W+1)'(QUEUE_DEPTH);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f1_vld_reg <= 1'b0;
            f2_vld_reg <= 1'b0;
        end else begin
            f1_vld_reg <= in_valid && in_ready;
            f2_vld_reg <= f1_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        wx_reg <= w_s * x_s;
        yz_reg <= y_s * z_s;
        xx_reg <= x_s * x_s;
        yy_reg <= y_s * y_s;
        wy_reg <= w_s * y_s;
        zx_reg <= z_s * x_s;
        wz_reg <= w_s * z_s;
        xy_reg <= x_s * y_s;
        zz_reg <= z_s * z_s;
    end

    always_ff @(posedge aclk) begin
        logic signed [SW-1:0] sp_v;
        sp_v = (SW'(wy_reg) - SW'(zx_reg)) <<< 1;
        item_reg.sr      <= (SW'(wx_reg) + SW'(yz_reg)) <<< 1;
        item_reg.cr      <= ONE_Q30 - ((SW'(xx_reg) + SW'(yy_reg)) <<< 1);
        item_reg.sp      <= sp_v;
        item_reg.sy      <= (SW'(wz_reg) + SW'(xy_reg)) <<< 1;
        item_reg.cy      <= ONE_Q30 - ((SW'(yy_reg) + SW'(zz_reg)) <<< 1);
        item_reg.sat_pos <= sp_v >= ONE_Q30;
        item_reg.sat_neg <= sp_v <= -ONE_Q30;
    end

    assign push      = f2_vld_reg;
    assign push_item = item_reg;

endmodule

// File: rtl/core/qte_queue.sv
// Short queue between the front end and the arctangent back end.
module qte_queue import qte_pkg::*; (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             push,
    input  qte_item_t                        push_item,
    input  logic                             pop,
    output logic                             q_valid,
    output qte_item_t                        pop_item,
    output logic [$clog2(QUEUE_DEPTH+1)-1:0] q_count
);
    localparam int PW    = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH+1);

    qte_item_t      mem [0:QUEUE_DEPTH-1];
    logic [PW-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic           do_pop;

    assign q_valid  = count_reg != '0;
    assign do_pop   = pop && q_valid;
    assign pop_item = mem[rd_ptr_reg];
    assign q_count  = count_reg;

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= PW'(wr_ptr_reg + 1'b1);
            end
            if (do_pop) begin
                rd_ptr_reg <= PW'(rd_ptr_reg + 1'b1);
            end
            count_reg <= CNT_W'(count_reg + CNT_W'(push) - CNT_W'(do_pop));
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> (count_reg != CNT_W'(QUEUE_DEPTH)) || do_pop)
        else $error("queue written while full");
    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

endmodule

// File: rtl/core/qte_isqrt.sv
// Pipelined floor square root, one result bit per stage.
module qte_isqrt import qte_pkg::*; (
    input  logic        aclk,
    input  logic        en,
    input  logic [60:0] v_in,
    output logic [30:0] root
);
    logic [60:0] rem_reg [0:ISQRT_STEPS-1];
    logic [61:0] res_reg [0:ISQRT_STEPS-1];

    genvar k;
    generate
        for (k = 0; k < ISQRT_STEPS; k++) begin : g_step
            localparam logic [61:0] BITV = 62'(1) << (60 - 2*k);
            logic [60:0] rem_in;
            logic [61:0] res_in;
            logic [61:0] trial;
            if (k == 0) begin : g_first
                assign rem_in = v_in;
                assign res_in = '0;
            end else begin : g_next
                assign rem_in = rem_reg[k-1];
                assign res_in = res_reg[k-1];
            end
            assign trial = res_in + BITV;
            always_ff @(posedge aclk) begin
                if (en) begin
                    if ({1'b0, rem_in} >= trial) begin
                        rem_reg[k] <= 61'({1'b0, rem_in} - trial);
                        res_reg[k] <= (res_in >> 1) + BITV;
                    end else begin
                        rem_reg[k] <= rem_in;
                        res_reg[k] <= res_in >> 1;
                    end
                end
            end
        end
    endgenerate

    assign root = res_reg[ISQRT_STEPS-1][30:0];

endmodule

// File: rtl/core/qte_cordic.sv
// Pipelined CORDIC vectoring unit giving a four-quadrant arctangent.
module qte_cordic import qte_pkg::*; #(
    parameter int STAGES = DEF_CORDIC_STAGES
) (
    input  logic                 aclk,
    input  logic                 en,
    input  logic signed [SW-1:0] y_in,
    input  logic signed [SW-1:0] x_in,
    output logic signed [ZW-1:0] angle
);
    localparam int NS = (STAGES < ATAN_ENTRIES) ? STAGES : ATAN_ENTRIES;

    logic signed [CW-1:0] x_reg [0:NS];
    logic signed [CW-1:0] y_reg [0:NS];
    logic signed [ZW-1:0] z_reg [0:NS];
    logic                 zero_reg [0:NS];

    // Fold the left half-plane onto the right and preload the half turn.
    always_ff @(posedge aclk) begin
        if (en) begin
            zero_reg[0] <= (x_in == '0) && (y_in == '0);
            if (x_in < 0) begin
                z_reg[0] <= (y_in >= 0) ? HALF_TURN : -HALF_TURN;
                x_reg[0] <= CW'(-x_in) <<< 16;
                y_reg[0] <= CW'(-y_in) <<< 16;
            end else begin
                z_reg[0] <= '0;
                x_reg[0] <= CW'(x_in) <<< 16;
                y_reg[0] <= CW'(y_in) <<< 16;
            end
        end
    end

    genvar i;
    generate
        for (i = 0; i < NS; i++) begin : g_stage
            always_ff @(posedge aclk) begin
                if (en) begin
                    zero_reg[i+1] <= zero_reg[i];
                    if (y_reg[i] >= 0) begin
                        x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                        y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                        z_reg[i+1] <= z_reg[i] + ZW'(qte_atan(i));
                    end else begin
                        x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                        y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                        z_reg[i+1] <= z_reg[i] - ZW'(qte_atan(i));
                    end
                end
            end
        end
    endgenerate

    assign angle = zero_reg[NS] ? '0 : z_reg[NS];

endmodule

// File: rtl/core/qte_back.sv
// Back end: pitch cosine by square root, three arctangents, rounding and the output register.
module qte_back import qte_pkg::*; #(
    parameter int CORDIC_STAGES = DEF_CORDIC_STAGES
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          q_valid,
    input  qte_item_t     q_item,
    output logic          pop,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [15:0]   roll_angle,
    output logic [14:0]   pitch_angle,
    output logic [15:0]   yaw_angle
);
    localparam int NS  = (CORDIC_STAGES < ATAN_ENTRIES) ? CORDIC_STAGES : ATAN_ENTRIES;
    localparam int DLY = 3 + ISQRT_STEPS;
    localparam int L   = DLY + NS + 2;

    logic                 adv;
    logic [L-1:0]         vld_reg;
    qte_item_t            item_reg [0:DLY-1];
    logic [29:0]          absp_reg;
    logic [59:0]          sq_reg;
    logic [60:0]          v_reg;
    logic [30:0]          cp;
    logic [1:0]           flag_reg [0:NS];
    logic signed [ZW-1:0] z_roll, z_pitch, z_yaw;
    logic signed [SW-1:0] cp_x;
    logic signed [30:0]   sp_lo;
    logic [15:0]          roll_reg, yaw_reg;
    logic [14:0]          pitch_reg;

    function automatic logic signed [15:0] to_units(input logic signed [ZW-1:0] a,
                                                    input logic signed [15:0] limit);
        logic signed [ZW:0]    t;
        logic signed [ZW-16:0] r;
        t = (ZW+1)'(a) + (ZW+1)'(32768);
        r = (ZW-15)'(t >>> 16);
        if (r > (ZW-15)'(limit)) begin
            r = (ZW-15)'(limit);
        end
        if (r < -(ZW-15)'(limit)) begin
            r = -(ZW-15)'(limit);
        end
        return 16'(r);
    endfunction

    // Advance the whole pipeline unless the output register is held.
    assign adv       = !vld_reg[L-1] || out_ready;
    assign pop       = adv && q_valid;
    assign out_valid = vld_reg[L-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (adv) begin
            vld_reg <= {vld_reg[L-2:0], q_valid};
        end
    end

    assign sp_lo = q_item.sp[30:0];

    always_ff @(posedge aclk) begin
        if (adv) begin
            item_reg[0] <= q_item;
            for (int k = 1; k < DLY; k++) begin
                item_reg[k] <= item_reg[k-1];
            end
            absp_reg <= 30'((sp_lo < 0) ? -sp_lo : sp_lo);
            sq_reg   <= absp_reg * absp_reg;
            v_reg    <= (61'(1) << 60) - 61'(sq_reg);
        end
    end

    qte_isqrt u_isqrt (
        .aclk (aclk),
        .en   (adv),
        .v_in (v_reg),
        .root (cp)
    );

    assign cp_x = SW'(cp);

    qte_cordic #(.STAGES(CORDIC_STAGES)) u_roll (
        .aclk (aclk), .en (adv),
        .y_in (item_reg[DLY-1].sr), .x_in (item_reg[DLY-1].cr), .angle (z_roll)
    );

    qte_cordic #(.STAGES(CORDIC_STAGES)) u_pitch (
        .aclk (aclk), .en (adv),
        .y_in (item_reg[DLY-1].sp), .x_in (cp_x), .angle (z_pitch)
    );

    qte_cordic #(.STAGES(CORDIC_STAGES)) u_yaw (
        .aclk (aclk), .en (adv),
        .y_in (item_reg[DLY-1].sy), .x_in (item_reg[DLY-1].cy), .angle (z_yaw)
    );

    always_ff @(posedge aclk) begin
        if (adv) begin
            flag_reg[0] <= {item_reg[DLY-1].sat_pos, item_reg[DLY-1].sat_neg};
            for (int k = 1; k <= NS; k++) begin
                flag_reg[k] <= flag_reg[k-1];
            end
            roll_reg <= to_units(z_roll, LIMIT_180);
            yaw_reg  <= to_units(z_yaw, LIMIT_180);
            priority if (flag_reg[NS][1]) begin
                pitch_reg <= 15'(LIMIT_90);
            end else if (flag_reg[NS][0]) begin
                pitch_reg <= 15'(-LIMIT_90);
            end else begin
                pitch_reg <= 15'(to_units(z_pitch, LIMIT_90));
            end
        end
    end

    assign roll_angle  = roll_reg;
    assign pitch_angle = pitch_reg;
    assign yaw_angle   = yaw_reg;

    assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid |-> ($signed(pitch_reg) <= 15'sd11520) && ($signed(pitch_reg) >= -15'sd11520))
        else $error("pitch beyond ninety degrees");
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid |-> ($signed(roll_reg) <= LIMIT_180) && ($signed(roll_reg) >= -LIMIT_180)
                      && ($signed(yaw_reg) <= LIMIT_180) && ($signed(yaw_reg) >= -LIMIT_180))
        else $error("roll or yaw beyond half turn");

endmodule

// File: rtl/core/quaternion_to_euler_angles_core.sv
// Top level: quaternion in, roll, pitch and yaw out, one transaction per cycle unless stalled.
//
//  channel  dir  payload (lsb first)                          width
//  s_axis   in   quat_w, quat_x, quat_y, quat_z (16 b each)   64
//  m_axis   out  roll_angle 16, pitch_angle 15, yaw_angle 16  48
//
//  Takes one transaction per cycle while s_tready is high; the result delay is set by the 31-step
//  square root and the CORDIC stages (stages capped at 24).
//  Reset is synchronous on aresetn and clears only the valid flags, queue pointers and queue count.
//  A held output freezes the back end; the front keeps accepting until the
//  four-entry queue has no credit left.
module quaternion_to_euler_angles_core import qte_pkg::*; #(
    parameter int DATA_WIDTH    = DEF_DATA_WIDTH,
    parameter int CORDIC_STAGES = DEF_CORDIC_STAGES
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // quat_w, quat_x, quat_y, quat_z
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata    // roll_angle, pitch_angle, yaw_angle, one zero pad bit
);
    localparam int CNT_W = $clog2(QUEUE_DEPTH+1);

    logic             push, pop, q_valid;
    qte_item_t        push_item, pop_item;
    logic [CNT_W-1:0] q_count;
    logic [15:0]      roll_angle, yaw_angle;
    logic [14:0]      pitch_angle;

    qte_front #(.DATA_WIDTH(DATA_WIDTH)) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .quat_w    (s_tdata[15:0]),
        .quat_x    (s_tdata[31:16]),
        .quat_y    (s_tdata[47:32]),
        .quat_z    (s_tdata[63:48]),
        .q_count   (q_count),
        .push      (push),
        .push_item (push_item)
    );

    qte_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .q_valid   (q_valid),
        .pop_item  (pop_item),
        .q_count   (q_count)
    );

    qte_back #(.CORDIC_STAGES(CORDIC_STAGES)) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_valid     (q_valid),
        .q_item      (pop_item),
        .pop         (pop),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .roll_angle  (roll_angle),
        .pitch_angle (pitch_angle),
        .yaw_angle   (yaw_angle)
    );

    assign m_tdata = {1'b0, yaw_angle, pitch_angle, roll_angle};

endmodule

// File: dv/tb.sv
// Self-checking testbench for the quaternion to Euler angles core.
`timescale 1ns / 1ps

module tb;
    import qte_pkg::*;

    localparam int N_RANDOM = 530;

    typedef struct packed {
        logic signed [15:0] yaw;
        logic signed [14:0] pitch;
        logic signed [15:0] roll;
    } euler_t;

    typedef struct {
        logic signed [15:0] w, x, y, z;
        bit                 typed;
        euler_t             exp;
    } quat_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;

    euler_t angles_due[$];
    int     n_errors = 0;
    bit     hold_long = 1'b0;

    quaternion_to_euler_angles_core u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always #10 aclk = ~aclk;

    initial begin
        #100ms;
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic longint fshift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint cordic_angle(longint y, longint x);
        longint base, acc, xs, ys;
        base = 0;
        acc = 0;
        if (x == 0 && y == 0) return 0;
        if (x < 0) begin
            base = (y >= 0) ? 64'sd1509949440 : -64'sd1509949440;
            x = -x;
            y = -y;
        end
        x = x * 65536;
        y = y * 65536;
        for (int i = 0; i < DEF_CORDIC_STAGES && i < ATAN_ENTRIES; i++) begin
            xs = fshift(x, i);
            ys = fshift(y, i);
            if (y >= 0) begin
                x = x + ys; y = y - xs; acc += longint'(qte_atan(i));
            end else begin
                x = x - ys; y = y + xs; acc -= longint'(qte_atan(i));
            end
        end
        return base + acc;
    endfunction

    function automatic longint units_clamped(longint a, longint lim);
        longint r;
        r = fshift(a + 32768, 16);
        if (r > lim) r = lim;
        if (r < -lim) r = -lim;
        return r;
    endfunction

    function automatic longint int_sqrt(longint unsigned v);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return longint'(res);
    endfunction

    function automatic euler_t predict_angles(logic signed [15:0] qw, logic signed [15:0] qx,
                                              logic signed [15:0] qy, logic signed [15:0] qz);
        longint w, x, y, z, sr, cr, sp, sy, cy, pv;
        euler_t e;
        w = qw; x = qx; y = qy; z = qz;
        sr = 2 * (w * x + y * z);
        cr = 64'sd1073741824 - 2 * (x * x + y * y);
        e.roll = 16'(units_clamped(cordic_angle(sr, cr), 23040));
        sp = 2 * (w * y - z * x);
        if (sp >= 64'sd1073741824) pv = 11520;
        else if (sp <= -64'sd1073741824) pv = -11520;
        else pv = units_clamped(cordic_angle(sp,
                 int_sqrt((64'd1 << 60) - longint'(sp * sp))), 11520);
        e.pitch = 15'(pv);
        sy = 2 * (w * z + x * y);
        cy = 64'sd1073741824 - 2 * (y * y + z * z);
        e.yaw = 16'(units_clamped(cordic_angle(sy, cy), 23040));
        return e;
    endfunction

    task automatic send_quat(logic signed [15:0] w, logic signed [15:0] x,
                             logic signed [15:0] y, logic signed [15:0] z);
        s_tdata  <= {z, y, x, w};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        angles_due.push_back(predict_angles(w, x, y, z));
        @(negedge aclk);
    endtask

    task automatic pause_sender(int n);
        s_tvalid <= 1'b0;
        repeat (n) @(negedge aclk);
    endtask

    function automatic logic signed [15:0] rand_comp();
        case ($urandom_range(0, 5))
            0: return 16'sh8000;
            1: return 16'sh7fff;
            2: return 16'(int'($urandom_range(0, 600)) - 300);
            default: return 16'($urandom);
        endcase
    endfunction

    // Near-unit quaternion: random direction, scaled to length one.
    task automatic unit_quat(output logic signed [15:0] q[4]);
        real v[4], n;
        n = 0.0;
        for (int i = 0; i < 4; i++) begin
            v[i] = real'(int'($urandom_range(0, 20000)) - 10000);
            n += v[i] * v[i];
        end
        if (n == 0.0) begin v[0] = 1.0; n = 1.0; end
        n = $sqrt(n);
        for (int i = 0; i < 4; i++) q[i] = 16'($rtoi(v[i] / n * 32760.0));
    endtask

    // Receiver: own stall pattern, plus one long hold-off.
    initial begin
        int k;
        k = 0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            k++;
            if (hold_long) m_tready <= 1'b0;
            else if ((k / 64) % 3 == 0) m_tready <= 1'b1;
            else m_tready <= ($urandom_range(0, 3) != 0);
        end
    end

    always @(posedge aclk) begin
        euler_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[46:0];
            if (angles_due.size() == 0) begin
                $error("unexpected transaction %h", m_tdata);
                n_errors++;
            end else begin
                want = angles_due.pop_front();
                if (got.roll !== want.roll) begin
                    $error("roll_angle exp %0d got %0d", want.roll, got.roll); n_errors++;
                end
                if (got.pitch !== want.pitch) begin
                    $error("pitch_angle exp %0d got %0d", want.pitch, got.pitch); n_errors++;
                end
                if (got.yaw !== want.yaw) begin
                    $error("yaw_angle exp %0d got %0d", want.yaw, got.yaw); n_errors++;
                end
            end
        end
    end

    quat_row_t rows[$];

    function automatic quat_row_t mk(int w, int x, int y, int z, bit typed = 0,
                                     int r = 0, int p = 0, int yw = 0);
        quat_row_t q;
        q.w = 16'(w); q.x = 16'(x); q.y = 16'(y); q.z = 16'(z);
        q.typed = typed;
        q.exp.roll = 16'(r); q.exp.pitch = 15'(p); q.exp.yaw = 16'(yw);
        return q;
    endfunction

    initial begin
        logic signed [15:0] q[4];
        int burst, wait_cnt;
        rows = '{
            mk(32767, 0, 0, 0, 1, 0, 0, 0),        // identity
            mk(0, 0, 0, 0, 1, 0, 0, 0),            // all-zero quaternion
            mk(0, 16384, 16384, 0),                // both roll operands zero
            mk(32767, 0, 16385, 0, 1, 0, 11520, 0), // pitch saturates up
            mk(32767, 0, -16385, 0, 1, 0, -11520, 0), // pitch saturates down
            mk(0, 32767, 0, 0),                    // negative cosine, half turn roll
            mk(0, 0, 0, 32767),
            mk(0, 0, 32767, 0),
            mk(-32768, -32768, -32768, -32768),
            mk(32767, 32767, 32767, 32767),
            mk(-32768, 32767, -32768, 32767),
            mk(32767, -32768, 32767, -32768),
            mk(23170, 23170, 0, 0),
            mk(23170, -23170, 0, 0),
            mk(23170, 0, 0, 23170),
            mk(23170, 0, 0, -23170),
            mk(0, -32768, 1, 0),                   // zero roll sine at half turn roll
            mk(0, -32768, -1, 0),
            mk(16384, 16384, 16384, 16384),
            mk(28378, 0, 16384, 0),
            mk(-32768, 0, 0, 0),
            mk(21845, 0, 0, 0)                     // not of unit length
        };
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        foreach (rows[i]) begin
            send_quat(rows[i].w, rows[i].x, rows[i].y, rows[i].z);
            if (rows[i].typed && angles_due[$] !== rows[i].exp) begin
                $error("typed row %0d: exp %h model %h", i, rows[i].exp, angles_due[$]);
                n_errors++;
            end
        end
        // Long receiver hold-off while the sender keeps offering.
        hold_long = 1'b1;
        fork
            begin
                for (int i = 0; i < 100; i++) begin
                    unit_quat(q);
                    send_quat(q[0], q[1], q[2], q[3]);
                end
                s_tvalid <= 1'b0;
            end
            begin
                repeat (300) @(negedge aclk);
                hold_long = 1'b0;
            end
        join
        // Pause until the pipeline drains.
        s_tvalid <= 1'b0;
        while (angles_due.size() != 0) @(negedge aclk);
        for (int n = 0; n < N_RANDOM; ) begin
            burst = $urandom_range(1, 24);
            for (int b = 0; b < burst && n < N_RANDOM; b++, n++) begin
                if ($urandom_range(0, 3) != 0) unit_quat(q);
                else for (int c = 0; c < 4; c++) q[c] = rand_comp();
                send_quat(q[0], q[1], q[2], q[3]);
            end
            if ($urandom_range(0, 2) != 0) pause_sender($urandom_range(1, 12));
        end
        s_tvalid <= 1'b0;
        while (angles_due.size() != 0) @(negedge aclk);
        wait_cnt = 0;
        while (wait_cnt < 100) begin
            @(negedge aclk);
            wait_cnt++;
        end
        if (n_errors == 0 && angles_due.size() == 0) $display("RESULT: OK");
        else $display("RESULT: ERROR");
        $finish;
    end
endmodule
